@@ rtl/ps2m_pkg.sv @@
package ps2m_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_PACKET_LEN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOUSE_ID   = 1'd1;

    // Header byte bit positions
    localparam int unsigned HDR_SYNC_BIT  = 3;
    localparam int unsigned HDR_XSIGN_BIT = 4;
    localparam int unsigned HDR_YSIGN_BIT = 5;
    localparam int unsigned HDR_XOVF_BIT  = 6;
    localparam int unsigned HDR_YOVF_BIT  = 7;

    // Wheel mouse identify replies
    localparam logic [7:0] ID_WHEEL      = 8'h03;
    localparam logic [7:0] ID_WHEEL_5BTN = 8'h04;

    // Scroll direction codes
    localparam logic [1:0] SCROLL_NONE = 2'd0;
    localparam logic [1:0] SCROLL_UP   = 2'd1;
    localparam logic [1:0] SCROLL_DOWN = 2'd2;

    // Packet queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [2:0] packet_len;
        logic [7:0] mouse_id;
    } cfg_t;

    // One completed packet, already classified for scroll
    typedef struct packed {
        logic [7:0] hdr;
        logic [7:0] xb;
        logic [7:0] yb;
        logic [1:0] scroll;
    } pkt_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // 9-bit delta: overflow forces zero, a zero byte ignores its sign bit
    function automatic logic [8:0] decode_delta(input logic [7:0] b,
                                                input logic neg,
                                                input logic ovf);
        logic [8:0] v;
        v = {(neg && (b != 8'd0)), b};
        if (ovf) begin
            v = 9'd0;
        end
        return v;
    endfunction

endpackage

@@ rtl/ps2m_front.sv @@
module ps2m_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ps2m_pkg::cfg_t       cfg,
    input  logic                 accept,
    input  logic [7:0]           rx_byte,
    output logic                 push,
    output ps2m_pkg::pkt_t       pkt
);
    import ps2m_pkg::*;

    logic [1:0] pos_reg, pos_next;
    logic [7:0] hdr_reg, hdr_next;
    logic [7:0] xb_reg, xb_next;
    logic [7:0] yb_reg, yb_next;
    logic [2:0] eff_len;
    logic [2:0] pos_inc;
    logic       drop;

    assign eff_len = (cfg.packet_len >= 3'd4) ? 3'd4 : 3'd3;
    assign pos_inc = {1'b0, pos_reg} + 3'd1;
    assign drop    = (pos_reg == 2'd0) && !rx_byte[HDR_SYNC_BIT];

    always_comb begin
        pos_next   = pos_reg;
        hdr_next   = hdr_reg;
        xb_next    = xb_reg;
        yb_next    = yb_reg;
        push       = 1'b0;
        pkt.hdr    = (pos_reg == 2'd0) ? rx_byte : hdr_reg;
        pkt.xb     = (pos_reg == 2'd1) ? rx_byte : xb_reg;
        pkt.yb     = (pos_reg == 2'd2) ? rx_byte : yb_reg;
        pkt.scroll = SCROLL_NONE;
        if ((pos_reg == 2'd3) && (cfg.mouse_id inside {ID_WHEEL, ID_WHEEL_5BTN})) begin
            if (rx_byte[7]) begin
                pkt.scroll = SCROLL_UP;
            end else if (rx_byte != 8'd0) begin
                pkt.scroll = SCROLL_DOWN;
            end
        end
        if (accept && !drop) begin
            case (pos_reg)
                2'd0:    hdr_next = rx_byte;
                2'd1:    xb_next  = rx_byte;
                2'd2:    yb_next  = rx_byte;
                default: ;
            endcase
            if (pos_inc < eff_len) begin
                pos_next = pos_inc[1:0];
            end else begin
                pos_next = 2'd0;
                push     = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= 2'd0;
        end else begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        hdr_reg <= hdr_next;
        xb_reg  <= xb_next;
        yb_reg  <= yb_next;
    end

`ifndef NO_ASSERTIONS
    a_push_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (pos_reg == 2'd2 || pos_reg == 2'd3))
        else $error("packet completed before the delta bytes");
    a_wrap_on_push: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> (pos_reg == 2'd0))
        else $error("position not cleared after packet");
    a_drop_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && drop) |=> (pos_reg == 2'd0))
        else $error("out of sync byte advanced position");
`endif

endmodule

@@ rtl/ps2m_queue.sv @@
module ps2m_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  ps2m_pkg::pkt_t       push_pkt,
    input  logic                 pop,
    output ps2m_pkg::pkt_t       head_pkt,
    output ps2m_pkg::qstat_t     stat
);
    import ps2m_pkg::*;

    pkt_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        r = p + 1'b1;
        if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end
        return r;
    endfunction

    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head_pkt   = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_pkt;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !stat.full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !stat.empty)
        else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count past depth");
`endif

endmodule

@@ rtl/ps2m_back.sv @@
module ps2m_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ps2m_pkg::qstat_t     qstat,
    input  ps2m_pkg::pkt_t       pkt,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_buttons,
    output logic signed [8:0]    m_delta_x,
    output logic signed [8:0]    m_delta_y,
    output logic [1:0]           m_scroll_dir
);
    import ps2m_pkg::*;

    logic        valid_reg, valid_next;
    logic [2:0]  prev_btn_reg, prev_btn_next;
    logic [2:0]  btn_reg;
    logic [8:0]  dx_reg;
    logic [8:0]  dy_reg;
    logic [1:0]  scroll_reg;
    logic        slot_free;
    logic        fire;
    logic [2:0]  btn;
    logic [8:0]  dx;
    logic [8:0]  dy;

    assign slot_free = !valid_reg || m_ready;
    assign pop       = slot_free && !qstat.empty;

    assign btn  = pkt.hdr[2:0];
    assign dx   = decode_delta(pkt.xb, pkt.hdr[HDR_XSIGN_BIT], pkt.hdr[HDR_XOVF_BIT]);
    assign dy   = decode_delta(pkt.yb, pkt.hdr[HDR_YSIGN_BIT], pkt.hdr[HDR_YOVF_BIT]);
    assign fire = pop && ((btn != prev_btn_reg) || (dx != 9'd0) || (dy != 9'd0)
                          || (pkt.scroll != SCROLL_NONE));

    always_comb begin
        valid_next    = valid_reg;
        prev_btn_next = prev_btn_reg;
        if (slot_free) begin
            valid_next = fire;
        end
        if (fire) begin
            prev_btn_next = btn;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            prev_btn_reg <= 3'd0;
        end else begin
            valid_reg    <= valid_next;
            prev_btn_reg <= prev_btn_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            btn_reg    <= btn;
            dx_reg     <= dx;
            dy_reg     <= dy;
            scroll_reg <= pkt.scroll;
        end
    end

    assign m_valid      = valid_reg;
    assign m_buttons    = btn_reg;
    assign m_delta_x    = $signed(dx_reg);
    assign m_delta_y    = $signed(dy_reg);
    assign m_scroll_dir = scroll_reg;

`ifndef NO_ASSERTIONS
    a_no_neg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (dx_reg != 9'h100 && dy_reg != 9'h100))
        else $error("signed zero delta on output");
    a_scroll_code: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (scroll_reg != 2'd3))
        else $error("bad scroll code on output");
    a_prev_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> (prev_btn_reg == btn_reg))
        else $error("button history not updated with event");
`endif

endmodule

@@ rtl/ps2_mouse_packet_decoder.sv @@
// Path: a packet's last byte goes into the packet queue, then the back end pops it into the m_valid event register.
// Throughput: one request (byte) per cycle, sustained, while m_ready keeps up; the two-entry
//   packet queue between the byte front end and the decode back end absorbs a stalled output.
// Reset (aresetn, synchronous, active low): packet_len 3, mouse_id 0, byte position 0,
//   button history 0, queue empty, no event pending. Packet byte stores are not reset.
module ps2_mouse_packet_decoder (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [ps2m_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ps2m_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // received byte channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_rx_byte,
    // mouse event channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [2:0]                      m_buttons,
    output logic signed [8:0]               m_delta_x,
    output logic signed [8:0]               m_delta_y,
    output logic [1:0]                      m_scroll_dir
);
    import ps2m_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    logic    accept;
    logic    push;
    logic    pop;
    pkt_t    push_pkt;
    pkt_t    head_pkt;
    qstat_t  qstat;

    // Configuration registers: take a write on any cycle with the enable high.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_PACKET_LEN: cfg_next.packet_len = cfg_wdata[2:0];
                REG_MOUSE_ID:   cfg_next.mouse_id   = cfg_wdata[7:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.packet_len <= 3'd3;
            cfg_reg.mouse_id   <= 8'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Hold off new bytes only when the packet queue has no room; any byte may complete
    // a packet, so the front end stalls as a whole on a full queue.
    assign s_ready = !qstat.full;
    assign accept  = s_valid && s_ready;

    // Front end: regain sync, collect bytes, classify the wheel byte, push packets.
    ps2m_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .accept  (accept),
        .rx_byte (s_rx_byte),
        .push    (push),
        .pkt     (push_pkt)
    );

    // Short queue: lets the front keep taking bytes while the event output stalls.
    ps2m_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_pkt (push_pkt),
        .pop      (pop),
        .head_pkt (head_pkt),
        .stat     (qstat)
    );

    // Back end: decode deltas, filter idle packets, drive the event register.
    ps2m_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .qstat        (qstat),
        .pkt          (head_pkt),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_buttons    (m_buttons),
        .m_delta_x    (m_delta_x),
        .m_delta_y    (m_delta_y),
        .m_scroll_dir (m_scroll_dir)
    );

`ifndef NO_ASSERTIONS
    a_ready_tracks_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !qstat.full)
        else $error("ready high with full queue");
    a_len_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_we && cfg_index == REG_PACKET_LEN) |=> (cfg_reg.packet_len == $past(cfg_wdata[2:0])))
        else $error("packet length write lost");
    a_id_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_we && cfg_index == REG_MOUSE_ID) |=> (cfg_reg.mouse_id == $past(cfg_wdata)))
        else $error("mouse id write lost");
`endif

endmodule

@@ test/tb_ps2_mouse_packet_decoder.sv @@
module tb_ps2_mouse_packet_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import ps2m_pkg::*;

    // Cycles to let pass with nothing expected before a register write or the end
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 16;

    typedef enum logic [1:0] {
        REQ_BYTE,
        REQ_CFG,
        REQ_DRAIN,
        REQ_PHASE
    } req_kind_t;

    // One entry of the driver's work list: a byte, a register write,
    // a pause until all events are in, or a change of idling pattern
    typedef struct packed {
        req_kind_t              kind;
        logic [CFG_IDX_W-1:0]   index;
        logic [7:0]             data;
        logic [6:0]             idle_pct;
        logic [6:0]             stall_pct;
    } pending_req_t;

    typedef struct packed {
        logic [2:0]        buttons;
        logic signed [8:0] delta_x;
        logic signed [8:0] delta_y;
        logic [1:0]        scroll_dir;
    } mouse_event_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_rx_byte = 8'h00;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [2:0]            m_buttons;
    logic signed [8:0]     m_delta_x;
    logic signed [8:0]     m_delta_y;
    logic [1:0]            m_scroll_dir;

    ps2_mouse_packet_decoder u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_buttons    (m_buttons),
        .m_delta_x    (m_delta_x),
        .m_delta_y    (m_delta_y),
        .m_scroll_dir (m_scroll_dir)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Work list for the driver and events still owed by the block
    pending_req_t pending_reqs[$];
    mouse_event_t expected_events[$];

    // Idling pattern of the current phase, in percent of cycles
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    int unsigned error_count    = 0;
    int unsigned bytes_accepted = 0;
    int unsigned events_checked = 0;
    int unsigned cfg_writes     = 0;
    int unsigned quiet_cycles   = 0;

    // Decoder shadow: configuration as last written, plus packet assembly state
    logic [2:0]  cur_packet_len = 3'd3;
    logic [7:0]  cur_mouse_id   = 8'd0;
    logic [7:0]  pkt_store[3];
    int unsigned byte_pos       = 0;
    logic [2:0]  last_buttons   = 3'd0;

    // Generator's notion of the packet length, tracked as writes are queued
    int unsigned gen_len = 3;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    function automatic logic [8:0] signed_delta(input logic [7:0] mag, input logic sign,
                                                input logic ovf);
        if (ovf) return 9'd0;
        if (sign && mag != 8'd0) return {1'b1, mag};
        return {1'b0, mag};
    endfunction

    // Advance the packet assembler by one byte; return 1 when an event is due
    function automatic bit decode_mouse_byte(input logic [7:0] b, output mouse_event_t ev);
        logic [7:0]  hdr;
        logic [1:0]  scroll;
        logic [8:0]  dx;
        logic [8:0]  dy;
        int unsigned plen;
        ev = '0;
        plen = (cur_packet_len >= 3'd4) ? 4 : 3;
        // drop bytes without the sync bit while hunting for a header
        if (byte_pos == 0 && !b[HDR_SYNC_BIT]) return 1'b0;
        if (byte_pos < 3) pkt_store[byte_pos] = b;
        if (byte_pos + 1 < plen) begin
            byte_pos++;
            return 1'b0;
        end
        // a completing byte at the fourth slot is the wheel byte, whatever the length now is
        scroll = SCROLL_NONE;
        if (byte_pos == 3 && (cur_mouse_id == ID_WHEEL || cur_mouse_id == ID_WHEEL_5BTN)) begin
            if (b[7])
                scroll = SCROLL_UP;
            else if (b != 8'd0)
                scroll = SCROLL_DOWN;
        end
        byte_pos = 0;
        hdr = pkt_store[0];
        dx = signed_delta(pkt_store[1], hdr[HDR_XSIGN_BIT], hdr[HDR_XOVF_BIT]);
        dy = signed_delta(pkt_store[2], hdr[HDR_YSIGN_BIT], hdr[HDR_YOVF_BIT]);
        // suppress packets that move nothing and change no button
        if (hdr[2:0] == last_buttons && dx == 9'd0 && dy == 9'd0 && scroll == SCROLL_NONE)
            return 1'b0;
        last_buttons = hdr[2:0];
        ev.buttons    = hdr[2:0];
        ev.delta_x    = dx;
        ev.delta_y    = dy;
        ev.scroll_dir = scroll;
        return 1'b1;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        pending_req_t r;
        r = '0;
        r.kind = REQ_BYTE;
        r.data = b;
        pending_reqs.push_back(r);
    endtask

    task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        pending_req_t r;
        r = '0;
        r.kind  = REQ_CFG;
        r.index = idx;
        r.data  = value;
        pending_reqs.push_back(r);
        if (idx == REG_PACKET_LEN) gen_len = (value[2:0] >= 3'd4) ? 4 : 3;
    endtask

    task automatic push_drain();
        pending_req_t r;
        r = '0;
        r.kind = REQ_DRAIN;
        pending_reqs.push_back(r);
    endtask

    // Driver: hold each request until accepted, run register writes and pauses
    // only once the block has gone quiet, and update the shadow on every accept.
    always @(posedge aclk) begin : drive_requests
        pending_req_t         head;
        mouse_event_t         ev;
        logic                 accept;
        logic                 nv;
        logic [7:0]           nb;
        logic                 nwe;
        logic [CFG_IDX_W-1:0] nidx;
        logic [7:0]           nwd;
        nv   = 1'b0;
        nb   = s_rx_byte;
        nwe  = 1'b0;
        nidx = cfg_index;
        nwd  = cfg_wdata;
        if (aresetn) begin
            accept = s_valid && s_ready;
            if (accept) begin
                bytes_accepted++;
                if (decode_mouse_byte(s_rx_byte, ev)) expected_events.push_back(ev);
            end
            // hold the current request until it goes through
            nv = s_valid && !accept;
            if (accept || s_valid || expected_events.size() != 0)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (!nv && pending_reqs.size() != 0) begin
                head = pending_reqs[0];
                case (head.kind)
                    REQ_BYTE: begin
                        if ($urandom_range(99) >= send_idle_pct) begin
                            nv = 1'b1;
                            nb = head.data;
                            void'(pending_reqs.pop_front());
                        end
                    end
                    REQ_CFG: begin
                        // write only once every owed event is in and the pipe has settled
                        if (quiet_cycles >= SETTLE_CYCLES) begin
                            nwe  = 1'b1;
                            nidx = head.index;
                            nwd  = head.data;
                            if (head.index == REG_PACKET_LEN)
                                cur_packet_len = head.data[2:0];
                            else
                                cur_mouse_id = head.data;
                            cfg_writes++;
                            void'(pending_reqs.pop_front());
                        end
                    end
                    REQ_DRAIN: begin
                        if (quiet_cycles >= SETTLE_CYCLES) void'(pending_reqs.pop_front());
                    end
                    default: begin
                        send_idle_pct  = head.idle_pct;
                        recv_stall_pct = head.stall_pct;
                        void'(pending_reqs.pop_front());
                    end
                endcase
            end
        end
        s_valid   <= nv;
        s_rx_byte <= nb;
        cfg_we    <= nwe;
        cfg_index <= nidx;
        cfg_wdata <= nwd;
    end

    // Monitor: compare each event taken against the oldest owed one, field by field
    always @(posedge aclk) begin : check_events
        mouse_event_t want;
        logic         nr;
        nr = 1'b0;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                events_checked++;
                if (expected_events.size() == 0) begin
                    report_mismatch($sformatf(
                        "unexpected event buttons=%0d dx=%0d dy=%0d scroll=%0d",
                        m_buttons, m_delta_x, m_delta_y, m_scroll_dir));
                end else begin
                    want = expected_events.pop_front();
                    if (m_buttons !== want.buttons)
                        report_mismatch($sformatf("buttons got %0d want %0d",
                                                  m_buttons, want.buttons));
                    if (m_delta_x !== want.delta_x)
                        report_mismatch($sformatf("delta_x got %0d want %0d",
                                                  m_delta_x, want.delta_x));
                    if (m_delta_y !== want.delta_y)
                        report_mismatch($sformatf("delta_y got %0d want %0d",
                                                  m_delta_y, want.delta_y));
                    if (m_scroll_dir !== want.scroll_dir)
                        report_mismatch($sformatf("scroll_dir got %0d want %0d",
                                                  m_scroll_dir, want.scroll_dir));
                end
            end
            nr = ($urandom_range(99) >= recv_stall_pct);
        end
        m_ready <= nr;
    end

    // Stimulus: directed packets first, then random phases of packets and noise
    initial begin : stimulus
        pending_req_t r;
        logic [7:0]   hdr;
        logic [7:0]   b;
        logic [2:0]   prev_hdr_btn;
        int unsigned  chunk;
        int unsigned  n;
        logic [7:0]   corner_bytes[4];
        int unsigned  idle_tbl[4];
        int unsigned  stall_tbl[4];
        logic [2:0]   len_tbl[8];
        logic [7:0]   id_tbl[8];
        corner_bytes = '{8'h80, 8'hFF, 8'h01, 8'h7F};
        idle_tbl     = '{0, 64, 0, 32};
        stall_tbl    = '{0, 0, 64, 32};
        len_tbl      = '{3'd3, 3'd7, 3'd0, 3'd4, 3'd2, 3'd4, 3'd5, 3'd3};
        id_tbl       = '{8'd255, ID_WHEEL, 8'd0, ID_WHEEL_5BTN, ID_WHEEL_5BTN, ID_WHEEL,
                         8'($urandom), 8'd1};
        prev_hdr_btn = 3'd0;

        // Standard 3-byte packets, reset-like configuration written explicitly
        push_cfg(REG_PACKET_LEN, 8'd3);
        push_cfg(REG_MOUSE_ID, 8'd0);
        push_byte(8'h00);                   // no sync bit: drop
        push_byte(8'hF7);                   // every bit but sync: drop
        push_byte(8'h09); push_byte(8'hFF); push_byte(8'h00);
        // both signs set on zero deltas: stays zero, button release still reports
        push_byte(8'h38); push_byte(8'h00); push_byte(8'h00);
        // largest negative magnitude in x (-255) and -128 in y, with all buttons down
        push_byte(8'h3F); push_byte(8'h01); push_byte(8'h80);
        // both overflow bits force zero deltas; buttons unchanged, so nothing is reported
        push_byte(8'hCF); push_byte(8'h55); push_byte(8'hAA);

        // Length above the range acts as 4; wheel decoding on
        push_cfg(REG_PACKET_LEN, 8'd7);
        push_cfg(REG_MOUSE_ID, ID_WHEEL);
        push_byte(8'h08); push_byte(8'h00); push_byte(8'h00); push_byte(8'h7F);
        push_byte(8'h08); push_byte(8'h00); push_byte(8'h00); push_byte(8'h80);
        push_cfg(REG_MOUSE_ID, ID_WHEEL_5BTN);
        push_byte(8'h18); push_byte(8'h80); push_byte(8'h7F); push_byte(8'hFF);

        // Lower the length with three bytes of a wheel packet already in:
        // the next byte completes the packet as its wheel byte
        push_byte(8'h08); push_byte(8'h01); push_byte(8'h01);
        push_cfg(REG_PACKET_LEN, 8'd0);
        push_byte(8'h01);
        // 3-byte packet with a wheel ID: never any scroll
        push_byte(8'h0A); push_byte(8'h00); push_byte(8'h00);

        // Random part: four idling phases, two register settings each
        for (int c = 0; c < 8; c++) begin
            if (c % 2 == 0) begin
                r = '0;
                r.kind      = REQ_PHASE;
                r.idle_pct  = 7'(idle_tbl[c / 2]);
                r.stall_pct = 7'(stall_tbl[c / 2]);
                pending_reqs.push_back(r);
            end
            // exercise the unused upper bits of the length write as well
            push_cfg(REG_PACKET_LEN, {5'($urandom_range(31)), len_tbl[c]});
            push_cfg(REG_MOUSE_ID, id_tbl[c]);
            chunk = 0;
            while (chunk < 75) begin
                if ($urandom_range(9) < 8) begin
                    // well-formed packet: sync bit set, repeat buttons often, overflow rarely
                    hdr = 8'($urandom) | 8'h08;
                    if ($urandom_range(2) == 0) hdr[2:0] = prev_hdr_btn;
                    if ($urandom_range(3) != 0) hdr[7:6] = 2'b00;
                    prev_hdr_btn = hdr[2:0];
                    push_byte(hdr);
                    for (int k = 1; k < gen_len; k++) begin
                        case ($urandom_range(5))
                            0, 1:    b = 8'h00;
                            2:       b = corner_bytes[$urandom_range(3)];
                            default: b = 8'($urandom);
                        endcase
                        push_byte(b);
                    end
                    chunk += gen_len;
                end else begin
                    // noise: loose bytes that knock the framing out of step
                    n = $urandom_range(1, 3);
                    repeat (n) push_byte(8'($urandom));
                    chunk += n;
                end
            end
            // pause the sender until every owed event has come back
            push_drain();
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_reqs.size() != 0 || s_valid) @(posedge aclk);
        for (int i = 0; i < 4000 && expected_events.size() != 0; i++) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_events.size() != 0)
            report_mismatch($sformatf("%0d events never arrived", expected_events.size()));

        $display("Run covered %0d bytes and %0d events over %0d register writes,",
                 bytes_accepted, events_checked, cfg_writes);
        $display("in four idling phases with sync loss, overflow, wheel and length changes.");
        if (error_count == 0) begin
            $display("ps2_mouse_packet_decoder: match");
        end else begin
            $display("ps2_mouse_packet_decoder: mismatch");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin : watchdog
        #2_000_000;
        $display("Timeout with %0d requests pending and %0d events owed",
                 pending_reqs.size(), expected_events.size());
        $display("ps2_mouse_packet_decoder: mismatch");
        $finish;
    end

endmodule

@@ ps2_mouse_packet_decoder.f @@
rtl/ps2m_pkg.sv
rtl/ps2m_front.sv
rtl/ps2m_queue.sv
rtl/ps2m_back.sv
rtl/ps2_mouse_packet_decoder.sv
test/tb_ps2_mouse_packet_decoder.sv
